### hw/rtl/cpc_pkg.sv
// Shared definitions for the convergence patience checker.
// Holds widths, register indexes, request codes and the structs passed
// between the merge stage, the output buffer and the top level.
package cpc_pkg;

  localparam int NUM_PARAMS = 6;
  localparam int MAX_LANES  = 6;
  localparam int DATA_W     = 32;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int THR_W      = 31;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register indexes on the configuration port. Thresholds occupy
  // indexes 0 up to MAX_LANES-1, the patience limit follows.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_END  = CFG_IDX_W'(MAX_LANES);
  localparam logic [CFG_IDX_W-1:0] CFG_PATIENCE_LIMIT = CFG_IDX_W'(MAX_LANES);

  localparam logic [CNT_W-1:0] PATIENCE_MAX      = '1;
  localparam logic [CNT_W-1:0] PATIENCE_LIMIT_RST = CNT_W'(1);

  typedef enum logic {
    FUNC_CHECK = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_t;

  typedef struct packed {
    logic             converged;
    logic             improved;
    logic [CNT_W-1:0] patience_count;
  } result_t;

  typedef struct packed {
    logic             load_best;
    logic             set_seeded;
    logic [CNT_W-1:0] patience_next;
  } update_t;

endpackage

### hw/rtl/cpc_lane.sv
// One parameter lane of the convergence patience checker.
// Forms the exact 33-bit difference against the stored best value and
// compares its magnitude with the lane threshold. Uses cpc_pkg.
module cpc_lane (
  input  logic signed [cpc_pkg::DATA_W-1:0] best,
  input  logic signed [cpc_pkg::DATA_W-1:0] cur,
  input  logic        [cpc_pkg::THR_W-1:0]  threshold,
  output logic                              significant
);

  logic [cpc_pkg::DIFF_W-1:0] diff;
  logic [cpc_pkg::DIFF_W-1:0] mag;

  always_comb begin
    diff = {best[cpc_pkg::DATA_W-1], best} - {cur[cpc_pkg::DATA_W-1], cur};
    mag  = diff[cpc_pkg::DIFF_W-1] ? (cpc_pkg::DIFF_W'(0) - diff) : diff;
    significant = (mag >= {{(cpc_pkg::DIFF_W - cpc_pkg::THR_W){1'b0}}, threshold});
  end

endmodule

### hw/rtl/cpc_merge.sv
// Merge stage of the convergence patience checker.
// Combines the lane flags with the cost compare and works out the next
// patience count, the best-value update and the result. Uses cpc_pkg.
module cpc_merge (
  input  cpc_pkg::func_t                    func,
  input  logic                              seeded,
  input  logic signed [cpc_pkg::DATA_W-1:0] cost,
  input  logic signed [cpc_pkg::DATA_W-1:0] best_cost,
  input  logic [cpc_pkg::NUM_PARAMS-1:0]    lane_sig,
  input  logic [cpc_pkg::CNT_W-1:0]         patience,
  input  logic [cpc_pkg::CNT_W-1:0]         limit,
  output cpc_pkg::update_t                  upd,
  output cpc_pkg::result_t                  res
);

  logic better;
  logic any_sig;

  always_comb begin
    better  = (cost < best_cost);
    any_sig = |lane_sig;

    upd.load_best     = 1'b0;
    upd.set_seeded    = 1'b0;
    upd.patience_next = patience;
    res.improved      = 1'b0;
    res.converged     = 1'b0;

    case (func)
      cpc_pkg::FUNC_CLEAR: begin
        upd.patience_next = '0;
        res.converged     = (limit == '0);
      end
      cpc_pkg::FUNC_CHECK: begin
        if (!seeded) begin
          // The first check only records the starting point.
          upd.load_best  = 1'b1;
          upd.set_seeded = 1'b1;
        end else begin
          upd.load_best = better;
          res.improved  = better;
          if (better && any_sig) begin
            upd.patience_next = '0;
          end else if (patience != cpc_pkg::PATIENCE_MAX) begin
            upd.patience_next = patience + cpc_pkg::CNT_W'(1);
          end
          res.converged = (upd.patience_next >= limit);
        end
      end
      default: begin
        upd.patience_next = patience;
      end
    endcase

    res.patience_count = upd.patience_next;
  end

endmodule

### hw/rtl/cpc_out_buf.sv
// Two-entry output buffer of the convergence patience checker.
// An output register plus a skid register, so a request is taken while a
// result still waits downstream. Uses cpc_pkg.
module cpc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cpc_pkg::result_t din,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output cpc_pkg::result_t dout
);

  logic             skid_valid;
  cpc_pkg::result_t skid;
  logic             take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      // Output slot frees up: the skid entry is older than any new push.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        dout <= skid;
      end else if (push) begin
        dout <= din;
      end
    end else if (push) begin
      skid <= din;
    end
  end

endmodule

### hw/rtl/convergence_patience_checker.sv
// Convergence patience checker: the result of an accepted request shows on out_valid
// in the next cycle when the output buffer is empty, later only while out_stall holds.
// Throughput is one request per cycle while in_stall is low; the patience and
// best-value registers update in the cycle a request is accepted. Synchronous
// active-high reset empties the output buffer, clears the seeded flag and the
// patience count, and sets thresholds to 0 and the patience limit to 1.
module convergence_patience_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic signed [cpc_pkg::DATA_W-1:0] param_0,
  input  logic signed [cpc_pkg::DATA_W-1:0] param_1,
  input  logic signed [cpc_pkg::DATA_W-1:0] param_2,
  input  logic signed [cpc_pkg::DATA_W-1:0] param_3,
  input  logic signed [cpc_pkg::DATA_W-1:0] param_4,
  input  logic signed [cpc_pkg::DATA_W-1:0] param_5,
  input  logic signed [cpc_pkg::DATA_W-1:0] cost,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              converged,
  output logic                              improved,
  output logic [cpc_pkg::CNT_W-1:0]         patience_count
);

  // Request payload gathered into lane order.
  logic signed [cpc_pkg::DATA_W-1:0] cur [cpc_pkg::MAX_LANES];

  // Configuration registers.
  logic [cpc_pkg::THR_W-1:0] threshold [cpc_pkg::MAX_LANES];
  logic [cpc_pkg::CNT_W-1:0] limit;

  // Tracking state. The best values are only read once seeded is set, so
  // they need no reset.
  logic                              seeded;
  logic [cpc_pkg::CNT_W-1:0]         patience;
  logic signed [cpc_pkg::DATA_W-1:0] best_cost;
  logic signed [cpc_pkg::DATA_W-1:0] best_params [cpc_pkg::NUM_PARAMS];

  logic [cpc_pkg::NUM_PARAMS-1:0] lane_sig;
  cpc_pkg::update_t               upd;
  cpc_pkg::result_t               res;
  cpc_pkg::result_t               dout;
  logic                           accept;

  assign cur[0] = param_0;
  assign cur[1] = param_1;
  assign cur[2] = param_2;
  assign cur[3] = param_3;
  assign cur[4] = param_4;
  assign cur[5] = param_5;

  assign accept = in_valid && !in_stall;

  // Threshold writes land at indexes below the lane count; the patience
  // limit sits right after them. Any other index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cpc_pkg::MAX_LANES; i++) begin
        threshold[i] <= '0;
      end
      limit <= cpc_pkg::PATIENCE_LIMIT_RST;
    end else if (cfg_write) begin
      if (cfg_index < cpc_pkg::CFG_THRESHOLD_END) begin
        threshold[cfg_index] <= cfg_data;
      end else if (cfg_index == cpc_pkg::CFG_PATIENCE_LIMIT) begin
        limit <= cfg_data[cpc_pkg::CNT_W-1:0];
      end
    end
  end

  // One lane per parameter; each compares its own difference against its
  // threshold in parallel with the others.
  for (genvar g = 0; g < cpc_pkg::NUM_PARAMS; g++) begin : g_lane
    cpc_lane u_lane (
      .best        (best_params[g]),
      .cur         (cur[g]),
      .threshold   (threshold[g]),
      .significant (lane_sig[g])
    );
  end

  // The merge stage ORs the lane flags, compares the cost and decides the
  // next count, whether the best values reload and what the result reports.
  cpc_merge u_merge (
    .func      (cpc_pkg::func_t'(func)),
    .seeded    (seeded),
    .cost      (cost),
    .best_cost (best_cost),
    .lane_sig  (lane_sig),
    .patience  (patience),
    .limit     (limit),
    .upd       (upd),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded   <= 1'b0;
      patience <= '0;
    end else if (accept) begin
      patience <= upd.patience_next;
      if (upd.set_seeded) begin
        seeded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && upd.load_best) begin
      best_cost <= cost;
      for (int i = 0; i < cpc_pkg::NUM_PARAMS; i++) begin
        best_params[i] <= cur[i];
      end
    end
  end

  // The output buffer decouples the result side; the input side stalls only
  // when both buffer entries are taken.
  cpc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (dout)
  );

  assign converged      = dout.converged;
  assign improved       = dout.improved;
  assign patience_count = dout.patience_count;

endmodule

### hw/rtl/cpc_checker.sv
// Port-level checks for the convergence patience checker.
// Watches only the top-level handshake and result ports; bound to
// convergence_patience_checker at the end of this file. Uses cpc_pkg.
module cpc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      converged,
  input logic                      improved,
  input logic [cpc_pkg::CNT_W-1:0] patience_count
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(converged) &&
      $stable(improved) && $stable(patience_count))
    else $error("stalled result changed or vanished");

  // Every accepted request is followed by a valid result (not necessarily its own) on the next cycle.
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no visible result");

  // The input side only stalls when the output register is occupied.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output");

  // Reset empties the buffer and opens the input side.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left the output buffer occupied");

endmodule

bind convergence_patience_checker cpc_checker u_cpc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .converged      (converged),
  .improved       (improved),
  .patience_count (patience_count)
);
